>>> design/aging_priority_run_queues_unit_macros.svh
// Assertion macros for the run queue unit.
// Used by the top level only.
`ifndef AGING_PRIORITY_RUN_QUEUES_UNIT_MACROS_SVH
`define AGING_PRIORITY_RUN_QUEUES_UNIT_MACROS_SVH
// implication checked on every clock, quiet during reset
`define APRQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define APRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> design/aprq_pkg.sv
// Shared types and codes for the run queue unit.
// No dependencies.
`timescale 1ns / 1ps
package aprq_pkg;
	localparam logic [1:0] MODE_PLACE = 2'd0;
	localparam logic [1:0] MODE_PUSH  = 2'd1;
	localparam logic [1:0] MODE_POP   = 2'd2;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NONE    = 2'd2;
	localparam logic [1:0] REG_ONLINE = 2'd0;
	localparam logic [1:0] REG_STEP   = 2'd1;
	localparam logic [1:0] REG_BONUS  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic latch;      // capture input item
		logic sel_start;  // pick target / victim queue, start scan
		logic do_enq;     // write enqueue
		logic rd_entry;   // read scan entry
		logic div_start;  // start bonus divider
		logic cmp;        // compare scanned entry with best
		logic do_deq;     // remove best entry
		logic fin;        // finish, strobe result
	} aprq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_pop;
		logic enq_ok;     // enqueue target can take the task
		logic pop_found;  // some queue to pop from
		logic scan_last;  // current entry is the last one
		logic div_done;
	} aprq_stat_t;
endpackage

>>> design/aprq_ctrl.sv
// Controller for the run queue unit: sequences enqueue and pop scans.
// Depends on aprq_pkg.
`timescale 1ns / 1ps
module aprq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  aprq_pkg::aprq_stat_t stat,
	output aprq_pkg::aprq_cmd_t  cmd
);
	typedef enum logic [2:0] {S_IDLE, S_SEL, S_DEC, S_RD, S_DIV, S_CMP, S_FIN} state_t;
	state_t state_q;

	// command decode from state
	always_comb begin
		cmd = '0;
		cmd.latch = start && !busy;
		case (state_q)
			S_SEL: cmd.sel_start = 1'b1;
			S_DEC: begin
				cmd.do_enq = !stat.is_pop && stat.enq_ok;
			end
			S_RD: cmd.rd_entry = 1'b1;
			S_DIV: cmd.div_start = 1'b1;
			S_CMP: begin
				cmd.cmp = stat.div_done;
				cmd.do_deq = stat.div_done && stat.scan_last;
			end
			S_FIN: cmd.fin = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_SEL;
				S_SEL: state_q <= S_DEC;
				S_DEC: state_q <= (stat.is_pop && stat.pop_found) ? S_RD : S_FIN;
				S_RD: state_q <= S_DIV;
				S_DIV: state_q <= S_CMP;
				S_CMP: begin
					if (stat.div_done) state_q <= stat.scan_last ? S_FIN : S_RD;
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> design/aprq_div.sv
// Radix-2 restoring divider for the aging bonus, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module aprq_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quot
);
	logic [31:0] q_q;
	logic [16:0] r_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [15:0] d_q;
	logic [16:0] r_sh;
	logic [16:0] r_sub;

	assign r_sh  = {r_q[15:0], q_q[31]};
	assign r_sub = r_sh - {1'b0, d_q};
	assign done  = !run_q && !go;
	assign quot  = q_q;

	// one shift-subtract step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 6'd0;
			q_q   <= dividend;
			r_q   <= '0;
			d_q   <= (divisor == 16'd0) ? 16'd1 : divisor;
		end else if (run_q) begin
			if (!r_sub[16]) begin
				r_q <= r_sub;
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[30:0], 1'b0};
			end
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd31) run_q <= 1'b0;
		end
	end
endmodule

>>> design/aprq_dp.sv
// Datapath for the run queue unit: queues, task tables, scan and selection.
// Depends on aprq_pkg and aprq_div.
`timescale 1ns / 1ps
module aprq_dp #(
	parameter int NUM_CPUS    = 4,
	parameter int QUEUE_DEPTH = 8,
	parameter int NUM_TASKS   = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aprq_pkg::aprq_cmd_t  cmd,
	output aprq_pkg::aprq_stat_t stat,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [15:0]          cfg_data,
	input  logic [1:0]           mode,
	input  logic [1:0]           cpu,
	input  logic [2:0]           task_id,
	input  logic [7:0]           priority_req,
	input  logic [31:0]          now_ms,
	input  logic [3:0]           busy_mask,
	output logic                 done,
	output logic [1:0]           status,
	output logic [2:0]           task_out,
	output logic [1:0]           cpu_out,
	output logic                 stolen
);
	localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int DW  = $clog2(QUEUE_DEPTH);
	localparam int NW  = $clog2(QUEUE_DEPTH + 1);
	localparam int TW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	// configuration
	logic [2:0]  online_q;
	logic [15:0] step_q;
	logic [7:0]  bonus_max_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q    <= 3'd1;
			step_q      <= 16'd100;
			bonus_max_q <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_idx)
				aprq_pkg::REG_ONLINE: online_q    <= cfg_data[2:0];
				aprq_pkg::REG_STEP:   step_q      <= cfg_data;
				aprq_pkg::REG_BONUS:  bonus_max_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// latched item
	logic [1:0]  mode_q;
	logic [1:0]  cpu_q;
	logic [2:0]  task_q;
	logic [7:0]  prio_q;
	logic [31:0] now_q;
	logic [3:0]  busy_q;
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode; cpu_q <= cpu; task_q <= task_id;
			prio_q <= priority_req; now_q <= now_ms; busy_q <= busy_mask;
		end
	end

	// state stores; each queue owns a power-of-two slice of qmem
	logic [NW-1:0] cnt_q [NUM_CPUS];
	logic [TW-1:0] qmem [NUM_CPUS*(2**DW)];
	logic [7:0]    base_mem [NUM_TASKS];
	logic [31:0]   time_mem [NUM_TASKS];

	// online limit
	logic [4:0] online_lim;
	always_comb begin
		online_lim = ({2'b0, online_q} > 5'(NUM_CPUS)) ? 5'(NUM_CPUS) : {2'b0, online_q};
	end

	// placement pick and steal victim (small per-cpu compare chain)
	logic [CW-1:0] pick_cpu, victim;
	logic          vic_found;
	logic [NW:0]   min_load, load_i;
	logic          pick_done;
	logic [NW-1:0] vbest;
	always_comb begin
		pick_cpu = '0; min_load = '1; pick_done = 1'b0; load_i = '0;
		victim = '0; vbest = '0; vic_found = 1'b0;
		for (int i = 0; i < NUM_CPUS; i++) begin
			if (5'(i) < online_lim) begin
				load_i = {1'b0, cnt_q[i]} + ((i < 4) ? (NW+1)'(busy_q[i % 4]) : '0);
				if (!pick_done) begin
					if (load_i == '0) begin
						pick_cpu = CW'(i); pick_done = 1'b1;
					end else if (load_i < min_load) begin
						min_load = load_i; pick_cpu = CW'(i);
					end
				end
				if (i != int'(cpu_q) && cnt_q[i] > vbest) begin
					vbest = cnt_q[i]; victim = CW'(i); vic_found = 1'b1;
				end
			end
		end
	end

	logic          cpu_valid;
	logic [CW-1:0] cpu_loc;
	assign cpu_valid = int'(cpu_q) < NUM_CPUS;
	assign cpu_loc   = CW'(cpu_q);

	// selected queue, captured at selection
	logic [CW-1:0] sel_q;
	logic          sel_ok_q;
	logic          stolen_q;
	logic [DW-1:0] idx_q;
	logic [DW-1:0] best_idx_q;
	logic [TW-1:0] best_task_q;
	logic [8:0]    best_p_q;
	logic [31:0]   best_t_q;
	logic          first_q;

	logic          enq_tgt_ok;
	logic [CW-1:0] enq_tgt;
	logic          sel_valid;
	always_comb begin
		sel_valid = 1'b1;
		if (mode_q == aprq_pkg::MODE_PLACE) begin
			enq_tgt = pick_cpu;
		end else begin
			enq_tgt = cpu_loc; sel_valid = cpu_valid;
		end
		enq_tgt_ok = sel_valid && (int'(task_q) < NUM_TASKS)
			&& (cnt_q[enq_tgt] < NW'(QUEUE_DEPTH));
	end

	// scan read data
	logic [TW-1:0] ent_q;
	logic [7:0]    ent_base_q;
	logic [31:0]   ent_time_q;
	logic [31:0]   waited;
	logic [31:0]   quot;
	logic          div_done;
	logic          div_go_q;
	assign waited = (now_q > ent_time_q) ? now_q - ent_time_q : 32'd0;

	// divider starts once the entry's stamp is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= cmd.div_start;
		end
	end

	aprq_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go_q), .dividend(waited),
		.divisor(step_q), .done(div_done), .quot(quot)
	);

	logic [7:0] bonus;
	logic [8:0] aged;
	assign bonus = (quot > {24'd0, bonus_max_q}) ? bonus_max_q : quot[7:0];
	assign aged  = {1'b0, ent_base_q} + {1'b0, bonus};

	logic better;
	assign better = first_q || aged > best_p_q || (aged == best_p_q && ent_time_q < best_t_q);

	logic [DW-1:0] last_idx;
	assign last_idx = DW'(cnt_q[sel_q] - NW'(1));

	always_ff @(posedge clk) begin
		if (cmd.rd_entry) begin
			ent_q      <= qmem[{sel_q, idx_q}];
		end
	end
	logic [TW-1:0] rd_task;
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			ent_base_q <= base_mem[ent_q];
			ent_time_q <= time_mem[ent_q];
		end
	end
	assign rd_task = ent_q;

	// queue and table writes
	logic [TW-1:0] fill_q;
	logic          fill_move_q;
	always_ff @(posedge clk) begin
		if (cmd.do_enq) begin
			base_mem[task_q[TW-1:0]] <= prio_q;
			time_mem[task_q[TW-1:0]] <= now_q;
			qmem[{enq_tgt, DW'(cnt_q[enq_tgt])}] <= task_q[TW-1:0];
		end else if (cmd.fin && fill_move_q) begin
			qmem[{sel_q, best_idx_q}] <= fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) cnt_q[i] <= '0;
			fill_move_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			fill_move_q <= 1'b0;
			if (cmd.do_enq) cnt_q[enq_tgt] <= cnt_q[enq_tgt] + NW'(1);
			if (cmd.sel_start) first_q <= 1'b1;
			if (cmd.cmp) first_q <= 1'b0;
			if (cmd.do_deq) begin
				cnt_q[sel_q] <= cnt_q[sel_q] - NW'(1);
				fill_move_q <= 1'b1;
			end
		end
	end

	// scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.sel_start) begin
			idx_q <= '0;
			if (cpu_valid && cnt_q[cpu_loc] != '0) begin
				sel_q <= cpu_loc; stolen_q <= 1'b0; sel_ok_q <= 1'b1;
			end else begin
				sel_q <= victim; stolen_q <= 1'b1; sel_ok_q <= vic_found;
			end
		end
		if (cmd.cmp) begin
			idx_q <= idx_q + DW'(1);
			if (better) begin
				best_p_q <= aged; best_t_q <= ent_time_q;
				best_idx_q <= idx_q; best_task_q <= rd_task;
			end
			// last entry is the one that fills the gap
			fill_q <= rd_task;
		end
	end

	assign stat = '{
		is_pop:    (mode_q == aprq_pkg::MODE_POP),
		enq_ok:    (mode_q == aprq_pkg::MODE_PLACE || mode_q == aprq_pkg::MODE_PUSH)
			&& enq_tgt_ok,
		pop_found: sel_ok_q,
		scan_last: (idx_q == last_idx),
		div_done:  div_done
	};

	// enqueue outcome held from selection cycle
	logic          enq_okd_q;
	logic [CW-1:0] enq_tgtd_q;
	always_ff @(posedge clk) begin
		if (cmd.sel_start) begin
			enq_okd_q  <= stat.enq_ok;
			enq_tgtd_q <= enq_tgt;
		end
	end

	// result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.fin;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status <= aprq_pkg::ST_NONE; task_out <= '0; cpu_out <= '0; stolen <= 1'b0;
			if (mode_q == aprq_pkg::MODE_PLACE || mode_q == aprq_pkg::MODE_PUSH) begin
				status  <= enq_okd_q ? aprq_pkg::ST_OK : aprq_pkg::ST_FULL;
				// push reports the named cpu even when it does not exist
				cpu_out <= (mode_q == aprq_pkg::MODE_PUSH) ? cpu_q : 2'(enq_tgtd_q);
			end else if (mode_q == aprq_pkg::MODE_POP && sel_ok_q) begin
				status   <= aprq_pkg::ST_OK;
				task_out <= 3'(best_task_q);
				cpu_out  <= 2'(sel_q);
				stolen   <= stolen_q;
			end
		end
	end
endmodule

>>> design/aging_priority_run_queues_unit.sv
// Per-CPU run queues with aging priority and work stealing.
// Place/push finish without a scan. Pop scans its queue entry by entry; each
// entry's bonus comes from the 32-step bonus divider shared over the scan.
// One item at a time; result strobed by done for one cycle, cannot be stalled.
// arst_n clears counts, config and control; queue and task tables are not cleared.
// Depends on aprq_pkg, aprq_ctrl, aprq_dp and the macros header.
`timescale 1ns / 1ps
`include "aging_priority_run_queues_unit_macros.svh"
module aging_priority_run_queues_unit #(
	parameter int NUM_CPUS    = 4,
	parameter int QUEUE_DEPTH = 8,
	parameter int NUM_TASKS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic [1:0]  mode,
	input  logic [1:0]  cpu,
	input  logic [2:0]  task_id,
	input  logic [7:0]  priority_req,
	input  logic [31:0] now_ms,
	input  logic [3:0]  busy_mask,
	output logic [1:0]  status,
	output logic [2:0]  task_out,
	output logic [1:0]  cpu_out,
	output logic        stolen
);
	aprq_pkg::aprq_cmd_t  cmd;
	aprq_pkg::aprq_stat_t stat;

	aprq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
	);

	aprq_dp #(.NUM_CPUS(NUM_CPUS), .QUEUE_DEPTH(QUEUE_DEPTH), .NUM_TASKS(NUM_TASKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.mode(mode), .cpu(cpu), .task_id(task_id), .priority_req(priority_req),
		.now_ms(now_ms), .busy_mask(busy_mask), .done(done), .status(status),
		.task_out(task_out), .cpu_out(cpu_out), .stolen(stolen)
	);

	`APRQ_ASSERT_NEXT(a_fin_done, cmd.fin, done, "finish without result strobe")
	`APRQ_ASSERT_IMP(a_done_status, done && stolen, status == aprq_pkg::ST_OK, "steal not ok")
	`APRQ_ASSERT_IMP(a_deq_pop, cmd.do_deq, stat.is_pop, "dequeue outside pop")
endmodule

>>> tb/sv/aging_priority_run_queues_unit_test.sv
// Self-checking testbench for aging_priority_run_queues_unit: directed table plus random phases,
// each result checked against its table row or the predictor. Depends on aprq_pkg and the DUT.
`timescale 1ns / 1ps
module aging_priority_run_queues_unit_test;
	localparam logic [1:0] MODE_BAD = 2'd3;
	localparam int NCPU = 4;
	localparam int QDEPTH = 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS = 150;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] task_out;
		logic [1:0] cpu_out;
		logic       stolen;
	} sched_res_t;

	typedef struct {
		logic [1:0]  mode;
		logic [1:0]  cpu;
		logic [2:0]  tid;
		logic [7:0]  pri;
		logic [31:0] now;
		logic [3:0]  bm;
		bit          chk;
		sched_res_t  res;
	} sched_row_t;

	logic clk, arst_n, start, busy, done, cfg_we;
	logic [1:0] cfg_idx;
	logic [15:0] cfg_data;
	logic [1:0] mode, cpu, status, cpu_out;
	logic [2:0] task_id, task_out;
	logic [7:0] priority_req;
	logic [31:0] now_ms;
	logic [3:0] busy_mask;
	logic stolen;

	// typed expectation travels with the item it belongs to
	bit row_chk;
	sched_res_t row_res;

	// predictor state
	logic [2:0]  rq_task [NCPU][QDEPTH];
	int          rq_count [NCPU];
	logic [7:0]  task_pri [8];
	logic [31:0] task_stamp [8];
	logic [2:0]  cfg_online;
	logic [15:0] cfg_step;
	logic [7:0]  cfg_bonus;

	sched_res_t pending_res[$];
	int mismatches;
	int watchdog;

	aging_priority_run_queues_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.mode(mode), .cpu(cpu), .task_id(task_id), .priority_req(priority_req),
		.now_ms(now_ms), .busy_mask(busy_mask),
		.status(status), .task_out(task_out), .cpu_out(cpu_out), .stolen(stolen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int online_count();
		return (cfg_online > NCPU) ? NCPU : int'(cfg_online);
	endfunction

	function automatic int aged_priority(logic [2:0] t, logic [31:0] now);
		logic [31:0] waited, stepv, bonus;
		waited = (now > task_stamp[t]) ? now - task_stamp[t] : 32'd0;
		stepv = (cfg_step == 16'd0) ? 32'd1 : {16'd0, cfg_step};
		bonus = waited / stepv;
		if (bonus > cfg_bonus)
			bonus = {24'd0, cfg_bonus};
		return int'(task_pri[t]) + int'(bonus);
	endfunction

	// remove the best aged entry; last entry fills the gap
	function automatic logic [2:0] take_best(int c, logic [31:0] now);
		int best, best_p, p, n;
		logic [2:0] t;
		n = rq_count[c];
		best = 0;
		best_p = aged_priority(rq_task[c][0], now);
		for (int i = 1; i < n; i++) begin
			p = aged_priority(rq_task[c][i], now);
			if (p > best_p || (p == best_p &&
					task_stamp[rq_task[c][i]] < task_stamp[rq_task[c][best]])) begin
				best_p = p;
				best = i;
			end
		end
		t = rq_task[c][best];
		rq_count[c] = n - 1;
		rq_task[c][best] = rq_task[c][n - 1];
		return t;
	endfunction

	function automatic sched_res_t schedule_item(logic [1:0] m, logic [1:0] c, logic [2:0] t,
			logic [7:0] pr, logic [31:0] now, logic [3:0] bm);
		sched_res_t r;
		int target, min_load, load, victim, best_cnt;
		bit found;
		r = '{status: aprq_pkg::ST_NONE, task_out: 3'd0, cpu_out: 2'd0, stolen: 1'b0};
		if (m == aprq_pkg::MODE_PLACE || m == aprq_pkg::MODE_PUSH) begin
			target = int'(c);
			if (m == aprq_pkg::MODE_PLACE) begin
				target = 0;
				min_load = 32'h7fffffff;
				for (int i = 0; i < online_count(); i++) begin
					if (!bm[i] && rq_count[i] == 0) begin
						target = i;
						break;
					end
					load = rq_count[i] + int'(bm[i]);
					if (load < min_load) begin
						min_load = load;
						target = i;
					end
				end
			end
			r.cpu_out = target[1:0];
			if (rq_count[target] >= QDEPTH) begin
				r.status = aprq_pkg::ST_FULL;
			end else begin
				r.status = aprq_pkg::ST_OK;
				task_pri[t] = pr;
				task_stamp[t] = now;
				rq_task[target][rq_count[target]] = t;
				rq_count[target]++;
			end
		end else if (m == aprq_pkg::MODE_POP) begin
			if (rq_count[c] != 0) begin
				r = '{status: aprq_pkg::ST_OK, task_out: take_best(int'(c), now), cpu_out: c,
					stolen: 1'b0};
			end else begin
				found = 0;
				victim = 0;
				best_cnt = 0;
				for (int i = 0; i < online_count(); i++) begin
					if (i != int'(c) && rq_count[i] > best_cnt) begin
						best_cnt = rq_count[i];
						victim = i;
						found = 1;
					end
				end
				if (found)
					r = '{status: aprq_pkg::ST_OK, task_out: take_best(victim, now),
						cpu_out: victim[1:0], stolen: 1'b1};
			end
		end
		return r;
	endfunction

	// accepted transfers feed the predictor; strobed results are checked
	always @(posedge clk) begin
		sched_res_t got, want;
		bit active;
		if (arst_n) begin
			active = 1'b0;
			if (done) begin
				active = 1'b1;
				got = '{status: status, task_out: task_out, cpu_out: cpu_out, stolen: stolen};
				if (pending_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", got);
				end else begin
					want = pending_res.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (start && !busy) begin
				active = 1'b1;
				want = schedule_item(mode, cpu, task_id, priority_req, now_ms, busy_mask);
				pending_res.push_back(row_chk ? row_res : want);
			end
			watchdog <= active ? 0 : watchdog + 1;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// one command transfer, preceded by an optional gap
	task automatic issue(sched_row_t row, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= row.mode;
		cpu <= row.cpu;
		task_id <= row.tid;
		priority_req <= row.pri;
		now_ms <= row.now;
		busy_mask <= row.bm;
		row_chk <= row.chk;
		row_res <= row.res;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// wait out all pending results, then write registers while the block is idle
	task automatic set_config(logic [2:0] onl, logic [15:0] stp, logic [7:0] bon);
		start <= 1'b0;
		do @(posedge clk); while (pending_res.size() != 0 || busy);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= aprq_pkg::REG_ONLINE;
		cfg_data <= {13'd0, onl};
		@(posedge clk);
		cfg_online = onl;
		cfg_idx <= aprq_pkg::REG_STEP;
		cfg_data <= stp;
		@(posedge clk);
		cfg_step = stp;
		cfg_idx <= aprq_pkg::REG_BONUS;
		cfg_data <= {8'd0, bon};
		@(posedge clk);
		cfg_bonus = bon;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		sched_row_t rows[$];
		sched_row_t r;
		logic [2:0] onl_tab [7];
		logic [15:0] stp_tab [7];
		logic [7:0] bon_tab [7];
		logic [31:0] clock_ms;
		int idle_pct, pop_pct, sel;

		onl_tab = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd1};
		stp_tab = '{16'd1, 16'd0, 16'hFFFF, 16'd50, 16'd1000, 16'd7, 16'd100};
		bon_tab = '{8'd255, 8'd0, 8'd255, 8'd3, 8'd20, 8'd1, 8'd8};
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = aprq_pkg::REG_ONLINE;
		cfg_data = '0;
		mode = aprq_pkg::MODE_PLACE;
		cpu = '0;
		task_id = '0;
		priority_req = '0;
		now_ms = '0;
		busy_mask = '0;
		row_chk = 0;
		row_res = '0;
		mismatches = 0;
		watchdog = 0;
		cfg_online = 3'd1;
		cfg_step = 16'd100;
		cfg_bonus = 8'd8;
		foreach (rq_count[i]) rq_count[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset configuration (one CPU online)
		rows.push_back('{aprq_pkg::MODE_POP, 2'd0, 3'd0, 8'd0, 32'd0, 4'd0, 1,
			'{aprq_pkg::ST_NONE, 3'd0, 2'd0, 1'b0}});
		rows.push_back('{MODE_BAD, 2'd3, 3'd7, 8'd255, 32'hFFFFFFFF, 4'hF, 1,
			'{aprq_pkg::ST_NONE, 3'd0, 2'd0, 1'b0}});
		rows.push_back('{aprq_pkg::MODE_PLACE, 2'd2, 3'd3, 8'd255, 32'd0, 4'd0, 1,
			'{aprq_pkg::ST_OK, 3'd0, 2'd0, 1'b0}});
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd3, 3'd7, 8'd0, 32'hFFFFFFFF, 4'hF, 1,
			'{aprq_pkg::ST_OK, 3'd0, 2'd3, 1'b0}});
		rows.push_back('{aprq_pkg::MODE_PLACE, 2'd1, 3'd1, 8'd0, 32'd5, 4'd1, 1,
			'{aprq_pkg::ST_OK, 3'd0, 2'd0, 1'b0}});
		rows.push_back('{aprq_pkg::MODE_POP, 2'd0, 3'd0, 8'd0, 32'd1000, 4'd0, 0, '0});
		// local queue empty: steal from the only online CPU, then nothing left
		rows.push_back('{aprq_pkg::MODE_POP, 2'd2, 3'd0, 8'd0, 32'd1000, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_POP, 2'd2, 3'd0, 8'd0, 32'd1000, 4'd0, 0, '0});
		// time before the stamp counts as no wait
		rows.push_back('{aprq_pkg::MODE_POP, 2'd3, 3'd0, 8'd0, 32'd0, 4'd0, 0, '0});
		// fill cpu 1 with ties on priority and stamp, then overflow it
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd1, 3'd0, 8'd0, 32'd100, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd1, 3'd1, 8'd255, 32'd50, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd1, 3'd2, 8'd10, 32'd200, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd1, 3'd3, 8'd10, 32'd200, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd1, 3'd4, 8'd7, 32'd0, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd1, 3'd5, 8'd200, 32'd900, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd1, 3'd6, 8'd10, 32'd150, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd1, 3'd7, 8'd3, 32'hFFFFFFF0, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_PUSH, 2'd1, 3'd0, 8'd1, 32'd1, 4'd0, 1,
			'{aprq_pkg::ST_FULL, 3'd0, 2'd1, 1'b0}});
		rows.push_back('{aprq_pkg::MODE_POP, 2'd1, 3'd0, 8'd0, 32'd2000, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_POP, 2'd1, 3'd0, 8'd0, 32'd2000, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_POP, 2'd1, 3'd0, 8'd0, 32'd0, 4'd0, 0, '0});
		rows.push_back('{aprq_pkg::MODE_POP, 2'd1, 3'd0, 8'd0, 32'h80000000, 4'd0, 0, '0});
		foreach (rows[i])
			issue(rows[i], 0);

		// random phases; each starts with a drain and a register update
		clock_ms = 32'd0;
		for (int ph = 0; ph < 7; ph++) begin
			set_config(onl_tab[ph], stp_tab[ph], bon_tab[ph]);
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 59;
				2: idle_pct = 0;
				default: idle_pct = 24;
			endcase
			pop_pct = (ph % 2) ? 30 : 55;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				r.chk = 0;
				r.res = '0;
				r.mode = (sel < pop_pct) ? aprq_pkg::MODE_POP : (sel < 97) ?
					(($urandom_range(0, 1) != 0) ? aprq_pkg::MODE_PLACE : aprq_pkg::MODE_PUSH)
					: MODE_BAD;
				r.cpu = 2'($urandom_range(0, 3));
				r.tid = 3'($urandom_range(0, 7));
				r.pri = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
					: 8'($urandom_range(0, 255));
				sel = $urandom_range(0, 19);
				if (sel == 0)
					clock_ms = $urandom;
				else if (sel == 1)
					clock_ms = clock_ms - $urandom_range(0, 500);
				else
					clock_ms = clock_ms + $urandom_range(0, 400);
				r.now = clock_ms;
				r.bm = 4'($urandom_range(0, 15));
				issue(r, ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0);
			end
		end

		// finish: drain and let the block settle
		start <= 1'b0;
		do @(posedge clk); while (pending_res.size() != 0);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
